[src/cpt_pkg.sv]
// ----------------------------------------------------------------------------
// cpt_pkg - shared definitions for the color palette table
// Field widths, operation and register codes, FSM states and the request,
// result and configuration structures used between the palette modules.
// ----------------------------------------------------------------------------
package cpt_pkg;

    // Default sizes handed to the top level parameters
    localparam int ENTRIES_DEF  = 256;
    localparam int CHANNELS_DEF = 4;

    // Fixed field widths
    localparam int CHAN_W     = 8;
    localparam int CHAN_MAX   = 4;
    localparam int IDX_PORT_W = 8;
    localparam int CNT_PORT_W = 9;
    localparam int ACT_W      = 3;

    // Stream and configuration port widths
    localparam int S_TDATA_W  = 40;
    localparam int S_TUSER_W  = 2;
    localparam int M_TDATA_W  = 56;
    localparam int M_TUSER_W  = 1;
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 9;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_ACTIVE_CHANNELS = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_MAX_ENTRIES     = 1'b1;

    // Reset values of the configuration registers
    localparam logic [ACT_W-1:0]      ACT_RESET = 3'd4;
    localparam logic [CNT_PORT_W-1:0] MAX_RESET = 9'd256;

    // Result status codes
    localparam logic STAT_OK  = 1'b0;
    localparam logic STAT_REJ = 1'b1;

    typedef enum logic [1:0] {
        OP_APPEND = 2'd0,
        OP_WRITE  = 2'd1,
        OP_READ   = 2'd2,
        OP_FIND   = 2'd3
    } op_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_EXEC,
        ST_RD_WAIT,
        ST_LH_WAIT,
        ST_SCAN,
        ST_DONE
    } state_t;

    typedef struct packed {
        logic [ACT_W-1:0]      active_channels;
        logic [CNT_PORT_W-1:0] max_entries;
    } cfg_t;

    typedef struct packed {
        op_t                               op;
        logic [IDX_PORT_W-1:0]             entry_index;
        logic [CHAN_MAX-1:0][CHAN_W-1:0]   chan;
    } req_t;

    typedef struct packed {
        logic                              status;
        logic [IDX_PORT_W-1:0]             result_index;
        logic [CHAN_MAX-1:0][CHAN_W-1:0]   chan;
        logic [CNT_PORT_W-1:0]             fill_count;
    } res_t;

endpackage

[src/color_palette_table.sv]
// ----------------------------------------------------------------------------
// color_palette_table - color palette with append, write, read and find
// Stream front end, configuration registers and output register around
// the palette sequencer.
//
//  Channel | Signals                          | Moves
//  --------+----------------------------------+------------------------------
//  s_*     | s_tvalid s_tready s_tdata s_tuser| one operation request
//  m_*     | m_tvalid m_tready m_tdata m_tuser| one result per request
//  cfg_*   | cfg_valid cfg_ready cfg_index    | register write
//          | cfg_data                         |
//
// One request is handled at a time: a new request is taken only after the
// result of the last one has been loaded into the output register. A find
// tries the last-hit entry first, if valid, and else scans the filled entries
// from entry 0 one by one through the single palette RAM read port.
// Reset clears the fill count and last hit; palette contents are kept.
// A result waiting in the output register does not block the next request.
// ----------------------------------------------------------------------------
module color_palette_table #(
    parameter int ENTRIES  = cpt_pkg::ENTRIES_DEF,
    parameter int CHANNELS = cpt_pkg::CHANNELS_DEF
) (
    input  logic                           clk,
    input  logic                           rst_n,
    // request stream
    input  logic                           s_tvalid,
    output logic                           s_tready,
    // entry_index[7:0], chan_0[15:8], chan_1[23:16], chan_2[31:24], chan_3[39:32]
    input  logic [cpt_pkg::S_TDATA_W-1:0]  s_tdata,
    // op[1:0]
    input  logic [cpt_pkg::S_TUSER_W-1:0]  s_tuser,
    // result stream
    output logic                           m_tvalid,
    input  logic                           m_tready,
    // result_index[7:0], out_chan_0[15:8], out_chan_1[23:16], out_chan_2[31:24],
    // out_chan_3[39:32], fill_count[48:40], zero[55:49]
    output logic [cpt_pkg::M_TDATA_W-1:0]  m_tdata,
    // status[0]
    output logic [cpt_pkg::M_TUSER_W-1:0]  m_tuser,
    // configuration writes
    input  logic                           cfg_valid,
    output logic                           cfg_ready,
    input  logic [cpt_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [cpt_pkg::CFG_DATA_W-1:0] cfg_data
);

    localparam int CH_W = cpt_pkg::CHAN_W;
    localparam int IPW  = cpt_pkg::IDX_PORT_W;
    localparam int PADW = cpt_pkg::M_TDATA_W - IPW - cpt_pkg::CHAN_MAX * CH_W
                          - cpt_pkg::CNT_PORT_W;

    cpt_pkg::cfg_t cfg_reg;
    cpt_pkg::req_t in_req;
    cpt_pkg::res_t res;
    logic          res_valid;
    logic          res_ready;

    logic                          m_valid_reg;
    logic [cpt_pkg::M_TDATA_W-1:0] m_data_reg;
    logic [cpt_pkg::M_TUSER_W-1:0] m_user_reg;

    // Unpack the request
    assign in_req.op          = cpt_pkg::op_t'(s_tuser[1:0]);
    assign in_req.entry_index = s_tdata[IPW-1:0];
    assign in_req.chan[0]     = s_tdata[IPW + 0*CH_W +: CH_W];
    assign in_req.chan[1]     = s_tdata[IPW + 1*CH_W +: CH_W];
    assign in_req.chan[2]     = s_tdata[IPW + 2*CH_W +: CH_W];
    assign in_req.chan[3]     = s_tdata[IPW + 3*CH_W +: CH_W];

    // Configuration registers
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.active_channels <= cpt_pkg::ACT_RESET;
            cfg_reg.max_entries     <= cpt_pkg::MAX_RESET;
        end
        else if (cfg_valid)
        begin
            unique case (cfg_index)
                cpt_pkg::CFG_ACTIVE_CHANNELS:
                begin
                    cfg_reg.active_channels <= cfg_data[cpt_pkg::ACT_W-1:0];
                end
                cpt_pkg::CFG_MAX_ENTRIES:
                begin
                    cfg_reg.max_entries <= cfg_data;
                end
                default:
                begin
                end
            endcase
        end
    end

    cpt_engine #(
        .ENTRIES  (ENTRIES),
        .CHANNELS (CHANNELS)
    ) u_engine (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg_reg),
        .in_valid  (s_tvalid),
        .in_ready  (s_tready),
        .in_req    (in_req),
        .res_valid (res_valid),
        .res_ready (res_ready),
        .res       (res)
    );

    // Output register, loads when empty or being drained
    assign res_ready = !m_valid_reg || m_tready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m_valid_reg <= 1'b0;
        end
        else if (res_ready)
        begin
            m_valid_reg <= res_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (res_ready && res_valid)
        begin
            m_data_reg <= {{PADW{1'b0}}, res.fill_count,
                           res.chan[3], res.chan[2], res.chan[1], res.chan[0],
                           res.result_index};
            m_user_reg <= res.status;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;
    assign m_tuser  = m_user_reg;

endmodule

[src/cpt_ram.sv]
// ----------------------------------------------------------------------------
// cpt_ram - generic single-port-write, single-port-read RAM
// One write and one read port, read data registered.
// ----------------------------------------------------------------------------
module cpt_ram #(
    parameter  int WIDTH = 32,
    parameter  int DEPTH = 256,
    localparam int AW    = $clog2(DEPTH)
) (
    input  logic             clk,
    input  logic             wr_en,
    input  logic [AW-1:0]    wr_addr,
    input  logic [WIDTH-1:0] wr_data,
    input  logic             rd_en,
    input  logic [AW-1:0]    rd_addr,
    output logic [WIDTH-1:0] rd_data
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    // Write port
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem_reg[wr_addr] <= wr_data;
        end
    end

    // Registered read port
    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data_reg <= mem_reg[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

[src/cpt_engine.sv]
// ----------------------------------------------------------------------------
// cpt_engine - palette operation sequencer
// Holds the palette RAM, fill count and last-hit entry, and runs one
// append, write, read or find request at a time through the RAM.
// ----------------------------------------------------------------------------
module cpt_engine #(
    parameter int ENTRIES  = cpt_pkg::ENTRIES_DEF,
    parameter int CHANNELS = cpt_pkg::CHANNELS_DEF
) (
    input  logic          clk,
    input  logic          rst_n,
    input  cpt_pkg::cfg_t cfg,
    input  logic          in_valid,
    output logic          in_ready,
    input  cpt_pkg::req_t in_req,
    output logic          res_valid,
    input  logic          res_ready,
    output cpt_pkg::res_t res
);

    localparam int IDX_W  = $clog2(ENTRIES);
    localparam int CNT_W  = $clog2(ENTRIES + 1);
    localparam int CH_W   = cpt_pkg::CHAN_W;
    localparam int CH_MAX = cpt_pkg::CHAN_MAX;
    localparam int WORD_W = CH_W * CHANNELS;
    localparam int IPW    = cpt_pkg::IDX_PORT_W;
    localparam int CPW    = cpt_pkg::CNT_PORT_W;
    localparam int AW     = cpt_pkg::ACT_W;

    cpt_pkg::state_t state_reg, state_next;

    // Control state
    logic [CNT_W-1:0] count_reg, count_next;
    logic [IDX_W-1:0] lh_reg, lh_next;
    logic             lh_valid_reg, lh_valid_next;
    logic [IDX_W-1:0] ptr_reg, ptr_next;

    // Request and result payload
    cpt_pkg::op_t            op_reg, op_next;
    logic [IPW-1:0]          idx_reg, idx_next;
    logic [WORD_W-1:0]       color_reg, color_next;
    logic                    res_status_reg, res_status_next;
    logic [IPW-1:0]          res_idx_reg, res_idx_next;
    logic [CH_MAX-1:0][CH_W-1:0] res_chan_reg, res_chan_next;

    // RAM port
    logic              wr_en;
    logic [IDX_W-1:0]  wr_addr;
    logic              rd_en;
    logic [IDX_W-1:0]  rd_addr;
    logic [WORD_W-1:0] rd_data;

    // Decisions
    logic [CPW-1:0] limit;
    logic [CPW-1:0] count_ext;
    logic [AW-1:0]  act_n;
    logic           app_ok;
    logic           idx_ok;
    logic           lh_try;
    logic           count_zero;
    logic           scan_last;
    logic           hit;

    cpt_ram #(
        .WIDTH (WORD_W),
        .DEPTH (ENTRIES)
    ) u_ram (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (color_reg),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    // Saturated configuration and range checks
    assign count_ext  = CPW'(count_reg);
    assign limit      = (cfg.max_entries > CPW'(ENTRIES)) ? CPW'(ENTRIES) : cfg.max_entries;
    assign act_n      = (cfg.active_channels > AW'(CHANNELS)) ? AW'(CHANNELS)
                                                              : cfg.active_channels;
    assign app_ok     = count_ext < limit;
    assign idx_ok     = {1'b0, idx_reg} < count_ext;
    assign lh_try     = lh_valid_reg && (CNT_W'(lh_reg) < count_reg);
    assign count_zero = (count_reg == '0);
    assign scan_last  = ((CNT_W'(ptr_reg) + CNT_W'(1)) == count_reg);

    // Compare the active channels of the word just read
    always_comb
    begin
        hit = 1'b1;
        for (int k = 0; k < CHANNELS; k++)
        begin
            if ((AW'(k) < act_n) &&
                (rd_data[k*CH_W +: CH_W] != color_reg[k*CH_W +: CH_W]))
            begin
                hit = 1'b0;
            end
        end
    end

    // Next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            cpt_pkg::ST_IDLE:
            begin
                if (in_valid)
                begin
                    state_next = cpt_pkg::ST_EXEC;
                end
            end
            cpt_pkg::ST_EXEC:
            begin
                unique case (op_reg) inside
                    cpt_pkg::OP_APPEND, cpt_pkg::OP_WRITE:
                    begin
                        state_next = cpt_pkg::ST_DONE;
                    end
                    cpt_pkg::OP_READ:
                    begin
                        state_next = idx_ok ? cpt_pkg::ST_RD_WAIT : cpt_pkg::ST_DONE;
                    end
                    cpt_pkg::OP_FIND:
                    begin
                        if (count_zero)
                        begin
                            state_next = cpt_pkg::ST_DONE;
                        end
                        else if (lh_try)
                        begin
                            state_next = cpt_pkg::ST_LH_WAIT;
                        end
                        else
                        begin
                            state_next = cpt_pkg::ST_SCAN;
                        end
                    end
                    default:
                    begin
                        state_next = cpt_pkg::ST_DONE;
                    end
                endcase
            end
            cpt_pkg::ST_RD_WAIT:
            begin
                state_next = cpt_pkg::ST_DONE;
            end
            cpt_pkg::ST_LH_WAIT:
            begin
                state_next = hit ? cpt_pkg::ST_DONE : cpt_pkg::ST_SCAN;
            end
            cpt_pkg::ST_SCAN:
            begin
                if (hit || scan_last)
                begin
                    state_next = cpt_pkg::ST_DONE;
                end
            end
            cpt_pkg::ST_DONE:
            begin
                if (res_ready)
                begin
                    state_next = cpt_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = cpt_pkg::ST_IDLE;
            end
        endcase
    end

    // Outputs, RAM control and register updates
    always_comb
    begin
        in_ready        = (state_reg == cpt_pkg::ST_IDLE);
        res_valid       = (state_reg == cpt_pkg::ST_DONE);
        wr_en           = 1'b0;
        wr_addr         = '0;
        rd_en           = 1'b0;
        rd_addr         = '0;
        count_next      = count_reg;
        lh_next         = lh_reg;
        lh_valid_next   = lh_valid_reg;
        ptr_next        = ptr_reg;
        op_next         = op_reg;
        idx_next        = idx_reg;
        color_next      = color_reg;
        res_status_next = res_status_reg;
        res_idx_next    = res_idx_reg;
        res_chan_next   = res_chan_reg;

        unique case (state_reg)
            cpt_pkg::ST_IDLE:
            begin
                // Take the request, channels above CHANNELS dropped
                if (in_valid)
                begin
                    op_next  = in_req.op;
                    idx_next = in_req.entry_index;
                    for (int k = 0; k < CHANNELS; k++)
                    begin
                        color_next[k*CH_W +: CH_W] = in_req.chan[k];
                    end
                    res_status_next = cpt_pkg::STAT_REJ;
                    res_idx_next    = '0;
                    res_chan_next   = '0;
                end
            end
            cpt_pkg::ST_EXEC:
            begin
                unique case (op_reg) inside
                    cpt_pkg::OP_APPEND:
                    begin
                        if (app_ok)
                        begin
                            wr_en           = 1'b1;
                            wr_addr         = count_reg[IDX_W-1:0];
                            res_idx_next    = IPW'(count_reg);
                            res_status_next = cpt_pkg::STAT_OK;
                            count_next      = count_reg + CNT_W'(1);
                        end
                    end
                    cpt_pkg::OP_WRITE:
                    begin
                        if (idx_ok)
                        begin
                            wr_en           = 1'b1;
                            wr_addr         = idx_reg[IDX_W-1:0];
                            res_idx_next    = idx_reg;
                            res_status_next = cpt_pkg::STAT_OK;
                        end
                    end
                    cpt_pkg::OP_READ:
                    begin
                        if (idx_ok)
                        begin
                            rd_en   = 1'b1;
                            rd_addr = idx_reg[IDX_W-1:0];
                        end
                    end
                    cpt_pkg::OP_FIND:
                    begin
                        // Last hit first, else start the scan at entry 0
                        if (!count_zero)
                        begin
                            rd_en    = 1'b1;
                            rd_addr  = lh_try ? lh_reg : '0;
                            ptr_next = '0;
                        end
                    end
                    default:
                    begin
                    end
                endcase
            end
            cpt_pkg::ST_RD_WAIT:
            begin
                res_status_next = cpt_pkg::STAT_OK;
                res_idx_next    = idx_reg;
                for (int k = 0; k < CHANNELS; k++)
                begin
                    res_chan_next[k] = rd_data[k*CH_W +: CH_W];
                end
            end
            cpt_pkg::ST_LH_WAIT:
            begin
                if (hit)
                begin
                    res_status_next = cpt_pkg::STAT_OK;
                    res_idx_next    = IPW'(lh_reg);
                end
                else
                begin
                    rd_en    = 1'b1;
                    rd_addr  = '0;
                    ptr_next = '0;
                end
            end
            cpt_pkg::ST_SCAN:
            begin
                // One entry compared per cycle, next read issued alongside
                if (hit)
                begin
                    res_status_next = cpt_pkg::STAT_OK;
                    res_idx_next    = IPW'(ptr_reg);
                    lh_next         = ptr_reg;
                    lh_valid_next   = 1'b1;
                end
                else if (!scan_last)
                begin
                    rd_en    = 1'b1;
                    rd_addr  = ptr_reg + IDX_W'(1);
                    ptr_next = ptr_reg + IDX_W'(1);
                end
            end
            cpt_pkg::ST_DONE:
            begin
            end
            default:
            begin
            end
        endcase
    end

    assign res.status       = res_status_reg;
    assign res.result_index = res_idx_reg;
    assign res.chan         = res_chan_reg;
    assign res.fill_count   = count_ext;

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= cpt_pkg::ST_IDLE;
            count_reg    <= '0;
            lh_reg       <= '0;
            lh_valid_reg <= 1'b0;
            ptr_reg      <= '0;
        end
        else
        begin
            state_reg    <= state_next;
            count_reg    <= count_next;
            lh_reg       <= lh_next;
            lh_valid_reg <= lh_valid_next;
            ptr_reg      <= ptr_next;
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        op_reg         <= op_next;
        idx_reg        <= idx_next;
        color_reg      <= color_next;
        res_status_reg <= res_status_next;
        res_idx_reg    <= res_idx_next;
        res_chan_reg   <= res_chan_next;
    end

    // Fill count stays within the palette
    assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_W'(ENTRIES))
        else $error("fill count beyond palette size");

    // RAM is never read and written in the same cycle
    assert property (@(posedge clk) disable iff (!rst_n)
        !(wr_en && rd_en))
        else $error("RAM read and write overlap");

    // Count only grows, by one, out of the execute step
    assert property (@(posedge clk) disable iff (!rst_n)
        (count_reg != $past(count_reg)) |->
            (($past(state_reg) == cpt_pkg::ST_EXEC) &&
             (count_reg == $past(count_reg) + CNT_W'(1))))
        else $error("fill count changed outside an append");

    // Scan pointer stays inside the filled range
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == cpt_pkg::ST_SCAN) |-> (CNT_W'(ptr_reg) < count_reg))
        else $error("scan pointer past fill count");

    // A recorded last hit always names a filled entry
    assert property (@(posedge clk) disable iff (!rst_n)
        lh_valid_reg |-> (CNT_W'(lh_reg) < count_reg))
        else $error("last hit outside filled range");

endmodule

[bench/testbench.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench - self-checking bench for color_palette_table
// Drives append, write, read and find requests on the request stream,
// computes the expected result of each accepted request with a local
// palette predictor and compares every result field by field. The
// configuration registers are rewritten between phases while the block is
// idle, the sender idles in bursts and the receiver stalls on its own pattern.
// ----------------------------------------------------------------------------
module testbench;

    localparam int NCHAN    = cpt_pkg::CHANNELS_DEF;
    localparam int NENT     = cpt_pkg::ENTRIES_DEF;
    localparam int N_PHASES = 11;

    // Clock and reset
    logic clk   = 1'b0;
    logic rst_n = 1'b0;

    // Block ports
    logic                           s_tvalid  = 1'b0;
    logic                           s_tready;
    logic [cpt_pkg::S_TDATA_W-1:0]  s_tdata   = '0;
    logic [cpt_pkg::S_TUSER_W-1:0]  s_tuser   = '0;
    logic                           m_tvalid;
    logic                           m_tready  = 1'b0;
    logic [cpt_pkg::M_TDATA_W-1:0]  m_tdata;
    logic [cpt_pkg::M_TUSER_W-1:0]  m_tuser;
    logic                           cfg_valid = 1'b0;
    logic                           cfg_ready;
    logic [cpt_pkg::CFG_IDX_W-1:0]  cfg_index = '0;
    logic [cpt_pkg::CFG_DATA_W-1:0] cfg_data  = '0;

    // Predictor state: palette, fill count, last hit and register copies
    logic [31:0] pal_mirror [0:NENT-1];
    int unsigned fill_cnt;
    int unsigned hit_idx;
    bit          hit_valid;
    int unsigned act_reg;
    int unsigned max_reg;

    // Expected results, oldest first
    cpt_pkg::res_t pending_results [$];
    int unsigned   err_count;
    int unsigned   burst_left;

    // Random phases: active channels, max entries, requests per phase
    int unsigned phase_act   [N_PHASES] = '{4, 1, 2, 3, 0, 6, 4, 2, 7, 4, 1};
    int unsigned phase_max   [N_PHASES] = '{16, 32, 48, 80, 96, 128, 200, 256, 511, 300, 0};
    int unsigned phase_items [N_PHASES] = '{50, 50, 50, 60, 50, 60, 70, 70, 80, 70, 40};

    color_palette_table u_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    // Compare the leading active channels of two colors
    function automatic bit colors_equal(logic [31:0] a, logic [31:0] b);
        int unsigned n;
        bit          same;
        n    = (act_reg > NCHAN) ? NCHAN : act_reg;
        same = 1'b1;
        for (int k = 0; k < n; k++)
        begin
            if (a[8*k +: 8] != b[8*k +: 8])
                same = 1'b0;
        end
        return same;
    endfunction

    // Apply one request to the palette copy and return its result
    function automatic cpt_pkg::res_t palette_predict(cpt_pkg::req_t rq);
        cpt_pkg::res_t rs;
        logic [31:0]   color;
        int unsigned   cap;
        bit            found;
        rs        = '0;
        rs.status = cpt_pkg::STAT_REJ;
        color     = '0;
        found     = 1'b0;
        for (int k = 0; k < NCHAN; k++)
            color[8*k +: 8] = rq.chan[k];
        case (rq.op)
            cpt_pkg::OP_APPEND:
            begin
                cap = (max_reg > NENT) ? NENT : max_reg;
                if (fill_cnt < cap)
                begin
                    pal_mirror[fill_cnt] = color;
                    rs.result_index      = fill_cnt[7:0];
                    rs.status            = cpt_pkg::STAT_OK;
                    fill_cnt++;
                end
            end
            cpt_pkg::OP_WRITE:
            begin
                if (rq.entry_index < fill_cnt)
                begin
                    pal_mirror[rq.entry_index] = color;
                    rs.result_index            = rq.entry_index;
                    rs.status                  = cpt_pkg::STAT_OK;
                end
            end
            cpt_pkg::OP_READ:
            begin
                if (rq.entry_index < fill_cnt)
                begin
                    rs.chan         = pal_mirror[rq.entry_index];
                    rs.result_index = rq.entry_index;
                    rs.status       = cpt_pkg::STAT_OK;
                end
            end
            default:
            begin
                if (fill_cnt != 0)
                begin
                    // last hit first, then a scan from entry zero
                    if (hit_valid && hit_idx < fill_cnt &&
                        colors_equal(color, pal_mirror[hit_idx]))
                    begin
                        rs.result_index = hit_idx[7:0];
                        rs.status       = cpt_pkg::STAT_OK;
                    end
                    else
                    begin
                        for (int i = 0; i < fill_cnt; i++)
                        begin
                            if (!found && colors_equal(color, pal_mirror[i]))
                            begin
                                found           = 1'b1;
                                hit_idx         = i;
                                hit_valid       = 1'b1;
                                rs.result_index = i[7:0];
                                rs.status       = cpt_pkg::STAT_OK;
                            end
                        end
                    end
                end
            end
        endcase
        rs.fill_count = fill_cnt[8:0];
        return rs;
    endfunction

    function automatic cpt_pkg::req_t mk_req(cpt_pkg::op_t op, logic [7:0] idx,
                                             logic [31:0] color);
        cpt_pkg::req_t rq;
        rq.op          = op;
        rq.entry_index = idx;
        rq.chan        = color;
        return rq;
    endfunction

    // Colors from a small set give duplicates for find
    function automatic logic [31:0] rand_color();
        logic [31:0] c;
        c = $urandom;
        if ($urandom_range(0, 9) < 3)
        begin
            for (int k = 0; k < 4; k++)
                c[8*k +: 8] = 8'($urandom_range(0, 3));
        end
        return c;
    endfunction

    // Send one request, idling in bursts, and record its expected result
    task automatic send_request(input cpt_pkg::req_t rq);
        int unsigned gap;
        if (burst_left == 0)
        begin
            gap = $urandom_range(0, 6);
            if (gap != 0)
            begin
                s_tvalid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(20, 40)
                                                      : $urandom_range(1, 8);
        end
        burst_left--;
        s_tvalid <= 1'b1;
        s_tdata  <= {rq.chan, rq.entry_index};
        s_tuser  <= rq.op;
        do @(posedge clk); while (!s_tready);
        pending_results.push_back(palette_predict(rq));
    endtask

    // Stop sending and wait until every result has come back
    task automatic wait_idle();
        s_tvalid <= 1'b0;
        while (pending_results.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic write_reg(input logic [cpt_pkg::CFG_IDX_W-1:0] idx,
                             input int unsigned val);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val[cpt_pkg::CFG_DATA_W-1:0];
        do @(posedge clk); while (!cfg_ready);
        cfg_valid <= 1'b0;
        if (idx == cpt_pkg::CFG_ACTIVE_CHANNELS)
            act_reg = val & 32'h7;
        else
            max_reg = val & 32'h1FF;
        @(posedge clk);
    endtask

    task automatic test_empty_palette();
        send_request(mk_req(cpt_pkg::OP_FIND, 8'h00, 32'h0000_0000));
        send_request(mk_req(cpt_pkg::OP_READ, 8'h00, 32'h0000_0000));
        send_request(mk_req(cpt_pkg::OP_WRITE, 8'hFF, 32'hFFFF_FFFF));
        wait_idle();
    endtask

    task automatic test_fill_limits();
        write_reg(cpt_pkg::CFG_MAX_ENTRIES, 0);
        send_request(mk_req(cpt_pkg::OP_APPEND, 8'hFF, 32'hFFFF_FFFF));
        wait_idle();
        write_reg(cpt_pkg::CFG_MAX_ENTRIES, 3);
        send_request(mk_req(cpt_pkg::OP_APPEND, 8'h00, 32'h0000_0000));
        send_request(mk_req(cpt_pkg::OP_APPEND, 8'h00, 32'hFFFF_FFFF));
        send_request(mk_req(cpt_pkg::OP_APPEND, 8'h00, 32'hF00F_A55A));
        send_request(mk_req(cpt_pkg::OP_APPEND, 8'h00, 32'h1111_1111));
        wait_idle();
    endtask

    task automatic test_read_write();
        send_request(mk_req(cpt_pkg::OP_READ, 8'd0, 32'hFFFF_FFFF));
        send_request(mk_req(cpt_pkg::OP_READ, 8'd1, 32'h0000_0000));
        send_request(mk_req(cpt_pkg::OP_READ, 8'd2, 32'h0000_0000));
        send_request(mk_req(cpt_pkg::OP_READ, 8'd3, 32'h0000_0000));
        send_request(mk_req(cpt_pkg::OP_READ, 8'd255, 32'h0000_0000));
        send_request(mk_req(cpt_pkg::OP_WRITE, 8'd1, 32'h7856_3412));
        send_request(mk_req(cpt_pkg::OP_READ, 8'd1, 32'h0000_0000));
        wait_idle();
    endtask

    task automatic test_find_rules();
        // scan hit, then last-hit hit
        send_request(mk_req(cpt_pkg::OP_FIND, 8'd0, 32'hF00F_A55A));
        send_request(mk_req(cpt_pkg::OP_FIND, 8'd0, 32'hF00F_A55A));
        // stale last hit: entry rewritten, old color no longer found
        send_request(mk_req(cpt_pkg::OP_WRITE, 8'd2, 32'hC3C3_3C3C));
        send_request(mk_req(cpt_pkg::OP_FIND, 8'd0, 32'hF00F_A55A));
        send_request(mk_req(cpt_pkg::OP_FIND, 8'd0, 32'hC3C3_3C3C));
        send_request(mk_req(cpt_pkg::OP_FIND, 8'd0, 32'h0000_0000));
        wait_idle();
        // one channel compared
        write_reg(cpt_pkg::CFG_ACTIVE_CHANNELS, 1);
        send_request(mk_req(cpt_pkg::OP_FIND, 8'd0, 32'hABCD_EF12));
        wait_idle();
        // no channel compared: anything matches
        write_reg(cpt_pkg::CFG_ACTIVE_CHANNELS, 0);
        send_request(mk_req(cpt_pkg::OP_FIND, 8'd0, 32'h9876_5432));
        wait_idle();
        // above the channel count saturates
        write_reg(cpt_pkg::CFG_ACTIVE_CHANNELS, 7);
        send_request(mk_req(cpt_pkg::OP_FIND, 8'd0, 32'h7856_3412));
        wait_idle();
        // max lowered below the fill count
        write_reg(cpt_pkg::CFG_MAX_ENTRIES, 1);
        send_request(mk_req(cpt_pkg::OP_APPEND, 8'd0, 32'h2222_2222));
        wait_idle();
    endtask

    // One random request shaped by the current palette contents
    task automatic random_request();
        cpt_pkg::req_t rq;
        int unsigned   cap;
        int unsigned   pick;
        int unsigned   eff_act;
        logic [31:0]   color;
        cap     = (max_reg > NENT) ? NENT : max_reg;
        eff_act = (act_reg > NCHAN) ? NCHAN : act_reg;
        pick    = $urandom_range(0, 99);
        color   = rand_color();
        rq      = mk_req(cpt_pkg::OP_FIND, 8'($urandom), color);
        if ((fill_cnt < cap && pick < 60) || pick < 10)
            rq.op = cpt_pkg::OP_APPEND;
        else
        begin
            pick = $urandom_range(0, 99);
            if (pick < 20)
                rq.op = cpt_pkg::OP_WRITE;
            else if (pick < 50)
                rq.op = cpt_pkg::OP_READ;
            if (rq.op != cpt_pkg::OP_FIND && fill_cnt != 0 && $urandom_range(0, 9) < 8)
                rq.entry_index = 8'($urandom_range(0, fill_cnt - 1));
            if (rq.op == cpt_pkg::OP_FIND && fill_cnt != 0)
            begin
                pick = $urandom_range(0, 99);
                if (pick < 60)
                    color = pal_mirror[$urandom_range(0, fill_cnt - 1)];
                else if (pick < 75 && hit_valid)
                    color = pal_mirror[hit_idx];
                // inactive channels do not take part in the compare
                if (pick < 75)
                begin
                    for (int k = eff_act; k < 4; k++)
                        color[8*k +: 8] = 8'($urandom);
                end
                rq.chan = color;
            end
        end
        send_request(rq);
    endtask

    task automatic test_random_phases();
        for (int p = 0; p < N_PHASES; p++)
        begin
            write_reg(cpt_pkg::CFG_ACTIVE_CHANNELS, phase_act[p]);
            write_reg(cpt_pkg::CFG_MAX_ENTRIES, phase_max[p]);
            repeat (phase_items[p]) random_request();
            wait_idle();
        end
    endtask

    task automatic check_field(input string name, input int unsigned want,
                               input int unsigned got);
        if (want != got)
        begin
            $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
            err_count++;
        end
    endtask

    // Result checker and receiver stall pattern
    int unsigned stall_cycle = 0;
    int unsigned stall_mode  = 0;
    int unsigned stall_hold  = 0;

    always @(posedge clk)
    begin
        cpt_pkg::res_t want;
        cpt_pkg::res_t got;
        bit            rdy;
        if (rst_n && m_tvalid && m_tready)
        begin
            got.status       = m_tuser[0];
            got.result_index = m_tdata[7:0];
            got.chan         = m_tdata[39:8];
            got.fill_count   = m_tdata[48:40];
            if (pending_results.size() == 0)
            begin
                $display("%0t: unexpected result, expected none, actual %0h/%0h",
                         $time, m_tuser, m_tdata);
                err_count++;
            end
            else
            begin
                want = pending_results.pop_front();
                check_field("status", 32'(want.status), 32'(got.status));
                check_field("result_index", 32'(want.result_index),
                            32'(got.result_index));
                for (int k = 0; k < 4; k++)
                    check_field($sformatf("out_chan_%0d", k), 32'(want.chan[k]),
                                32'(got.chan[k]));
                check_field("fill_count", 32'(want.fill_count), 32'(got.fill_count));
            end
        end
        stall_cycle++;
        if (stall_cycle % 100 == 0)
            stall_mode = $urandom_range(0, 3);
        case (stall_mode)
            0:       rdy = 1'b1;
            1:       rdy = ($urandom_range(0, 3) != 0);
            2:       rdy = ((stall_cycle % 5) >= 2);
            default:
            begin
                if (stall_hold != 0)
                begin
                    stall_hold--;
                    rdy = 1'b0;
                end
                else
                begin
                    rdy = 1'b1;
                    if ($urandom_range(0, 15) == 0)
                        stall_hold = $urandom_range(5, 20);
                end
            end
        endcase
        m_tready <= rdy;
    end

    // Run limit
    initial
    begin
        #20_000_000;
        $display("CHECKS FAILED");
        $finish;
    end

    initial
    begin
        fill_cnt   = 0;
        hit_idx    = 0;
        hit_valid  = 1'b0;
        act_reg    = 32'(cpt_pkg::ACT_RESET);
        max_reg    = 32'(cpt_pkg::MAX_RESET);
        err_count  = 0;
        burst_left = 0;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_empty_palette();
        test_fill_limits();
        test_read_write();
        test_find_rules();
        test_random_phases();

        s_tvalid <= 1'b0;
        while (pending_results.size() != 0)
            @(posedge clk);
        repeat (16) @(posedge clk);
        if (err_count == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

endmodule

[files.f]
src/cpt_pkg.sv
src/cpt_ram.sv
src/cpt_engine.sv
src/color_palette_table.sv
bench/testbench.sv
